// File: rtl/fmli_pkg.sv
// shared types, constants and the arctangent table of the fm modulator
package fmli_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 24;
  localparam int PHASE_W  = 32;
  localparam int IQ_W     = 16;

  // interpolation steps per sample, default
  localparam int STEPS_DEFAULT = 27;

  // cordic set-up: 24 rotations on 34-bit signed words
  localparam int CORDIC_ITERS = 24;
  localparam int ITER_W       = 5;
  localparam int CORDIC_W     = 34;
  localparam int ATAN_W       = 30;
  localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;

  // register map
  localparam logic              REG_PHASE_GAIN   = 1'b0;
  localparam logic [GAIN_W-1:0] PHASE_GAIN_RESET = 24'd712603;

  // handshake between the sequencer and the interpolator
  typedef struct packed {
    logic start;
    logic step;
  } lerp_ctrl_t;

  // arctangent of 2^-i at scale 2^32 per turn
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/fmli_cordic.sv
// iterative cordic rotator: one rotation per cycle, sine and cosine in q1.14
module fmli_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [fmli_pkg::PHASE_W-1:0]        phase,
  output logic                                done,
  output logic signed [fmli_pkg::IQ_W-1:0]    sin_out,
  output logic signed [fmli_pkg::IQ_W-1:0]    cos_out
);

  localparam int W  = fmli_pkg::CORDIC_W;
  localparam int IW = fmli_pkg::ITER_W;
  localparam int RW = W - 16;
  localparam logic signed [RW-1:0] QMAX = RW'(16384);
  localparam logic signed [RW-1:0] QMIN = -QMAX;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

  cstate_t               state;
  logic [IW-1:0]         iter;
  logic signed [W-1:0]   x;
  logic signed [W-1:0]   y;
  logic signed [W-1:0]   z;
  logic                  flip;

  logic                  start_flip;
  logic [fmli_pkg::PHASE_W-1:0] residual;
  logic signed [W-1:0]   dx;
  logic signed [W-1:0]   dy;
  logic signed [W-1:0]   angle;
  logic signed [fmli_pkg::IQ_W-1:0] s_q14;
  logic signed [fmli_pkg::IQ_W-1:0] c_q14;

  // round to q1.14 and clamp to plus or minus one
  function automatic logic signed [fmli_pkg::IQ_W-1:0] to_q14(input logic signed [W-1:0] v);
    logic signed [W-1:0]  t;
    logic signed [RW-1:0] r;
    logic signed [fmli_pkg::IQ_W-1:0] q;
    t = v + W'(32768);
    r = t[W-1:16];
    if (r > QMAX) begin
      q = fmli_pkg::IQ_W'(QMAX);
    end else if (r < QMIN) begin
      q = fmli_pkg::IQ_W'(QMIN);
    end else begin
      q = r[fmli_pkg::IQ_W-1:0];
    end
    return q;
  endfunction

  // fold quadrants two and three onto one and four
  assign start_flip = phase[fmli_pkg::PHASE_W-1] ^ phase[fmli_pkg::PHASE_W-2];
  assign residual   = phase ^ {start_flip, {(fmli_pkg::PHASE_W-1){1'b0}}};

  // shared shifter and angle lookup
  assign dx    = y >>> iter;
  assign dy    = x >>> iter;
  assign angle = $signed({{(W-fmli_pkg::ATAN_W){1'b0}}, fmli_pkg::atan_entry(iter)});

  assign s_q14 = to_q14(y);
  assign c_q14 = to_q14(x);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      iter  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            flip  <= start_flip;
            z     <= {{(W-fmli_pkg::PHASE_W){residual[fmli_pkg::PHASE_W-1]}}, residual};
            x     <= fmli_pkg::CORDIC_K;
            y     <= '0;
            iter  <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          if (!z[W-1]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - angle;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + angle;
          end
          iter <= iter + 1'b1;
          if (iter == IW'(fmli_pkg::CORDIC_ITERS - 1)) begin
            state <= C_FIN;
          end
        end
        C_FIN: begin
          sin_out <= flip ? -s_q14 : s_q14;
          cos_out <= flip ? -c_q14 : c_q14;
          done    <= 1'b1;
          state   <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/fmli_lerp.sv
// two-lane linear interpolator: divide by steps through a reciprocal multiply, then one point per step
module fmli_lerp #(
  parameter int STEPS = fmli_pkg::STEPS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fmli_pkg::lerp_ctrl_t              ctrl,
  input  logic signed [fmli_pkg::IQ_W-1:0]  prev_i,
  input  logic signed [fmli_pkg::IQ_W-1:0]  prev_q,
  input  logic signed [fmli_pkg::IQ_W-1:0]  new_i,
  input  logic signed [fmli_pkg::IQ_W-1:0]  new_q,
  output logic                              ready,
  output logic signed [fmli_pkg::IQ_W-1:0]  point_i,
  output logic signed [fmli_pkg::IQ_W-1:0]  point_q
);

  localparam int DW  = fmli_pkg::IQ_W;
  localparam int MW  = fmli_pkg::IQ_W;
  localparam int RW  = $clog2(2 * STEPS);
  localparam int SH  = MW + $clog2(STEPS);
  localparam int PRW = SH + MW;
  // ceil(2^SH / STEPS) gives an exact quotient for every 16-bit magnitude
  localparam longint RECIP_L = ((longint'(1) << SH) + longint'(STEPS) - 1) / longint'(STEPS);
  localparam logic [PRW-1:0] RECIP   = PRW'(RECIP_L);
  localparam logic [MW-1:0]  DIV_MW  = MW'(STEPS);
  localparam logic [RW-1:0]  DIVISOR = RW'(STEPS);
  localparam logic [RW-1:0]  HALF    = RW'(STEPS / 2);

  typedef enum logic [2:0] {L_IDLE, L_DIV, L_REM, L_PRIME, L_READY} lstate_t;

  lstate_t               state;
  logic signed [DW-1:0]  base   [2];
  logic                  neg    [2];
  logic [MW-1:0]         mag    [2];
  logic [MW-1:0]         quo    [2];
  logic [RW-1:0]         rem    [2];
  logic [MW-1:0]         acc_q  [2];
  logic [RW-1:0]         acc_r  [2];

  logic signed [DW-1:0]  prev_v [2];
  logic signed [DW-1:0]  new_v  [2];
  logic signed [DW:0]    diff   [2];
  logic [MW-1:0]         mag_in [2];
  logic [PRW-1:0]        prod   [2];
  logic [MW-1:0]         rem_full [2];
  logic [RW-1:0]         sum_r  [2];
  logic                  carry  [2];
  logic [MW-1:0]         acc_q_next [2];
  logic [RW-1:0]         acc_r_next [2];
  logic signed [DW:0]    offset [2];
  logic signed [DW:0]    point  [2];

  assign prev_v[0] = prev_i;
  assign prev_v[1] = prev_q;
  assign new_v[0]  = new_i;
  assign new_v[1]  = new_q;

  // per-lane arithmetic
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      diff[l]   = {new_v[l][DW-1], new_v[l]} - {prev_v[l][DW-1], prev_v[l]};
      mag_in[l] = diff[l][DW] ? MW'(-diff[l]) : MW'(diff[l]);
      // quotient by reciprocal, remainder by multiply back
      prod[l]     = PRW'(mag[l]) * RECIP;
      rem_full[l] = mag[l] - quo[l] * DIV_MW;
      // running quotient and remainder of j*|d| + steps/2
      sum_r[l]  = acc_r[l] + rem[l];
      carry[l]  = (sum_r[l] >= DIVISOR);
      acc_r_next[l] = carry[l] ? sum_r[l] - DIVISOR : sum_r[l];
      acc_q_next[l] = acc_q[l] + quo[l] + MW'(carry[l]);
      offset[l] = neg[l] ? -$signed({1'b0, acc_q[l]}) : $signed({1'b0, acc_q[l]});
      point[l]  = {base[l][DW-1], base[l]} + offset[l];
    end
  end

  assign point_i = point[0][DW-1:0];
  assign point_q = point[1][DW-1:0];
  assign ready   = (state == L_READY);

  // sequencer and lane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else if (ctrl.start) begin
      for (int l = 0; l < 2; l++) begin
        base[l]  <= prev_v[l];
        neg[l]   <= diff[l][DW];
        mag[l]   <= mag_in[l];
        acc_q[l] <= '0;
        acc_r[l] <= HALF;
      end
      state <= L_DIV;
    end else begin
      case (state)
        L_IDLE: state <= L_IDLE;
        L_DIV: begin
          for (int l = 0; l < 2; l++) begin
            quo[l] <= prod[l][PRW-1:SH];
          end
          state <= L_REM;
        end
        L_REM: begin
          for (int l = 0; l < 2; l++) begin
            rem[l] <= rem_full[l][RW-1:0];
          end
          state <= L_PRIME;
        end
        L_PRIME: begin
          for (int l = 0; l < 2; l++) begin
            acc_q[l] <= acc_q_next[l];
            acc_r[l] <= acc_r_next[l];
          end
          state <= L_READY;
        end
        L_READY: begin
          if (ctrl.step) begin
            for (int l = 0; l < 2; l++) begin
              acc_q[l] <= acc_q_next[l];
              acc_r[l] <= acc_r_next[l];
            end
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/fm_modulator_linear_interp_top.sv
// top level of the fm modulator with linear interpolation at its output
//
// Each accepted audio sample advances a wrapping 32-bit phase accumulator by
// sample * phase_gain and yields the sine (in_phase) and cosine (quadrature)
// of the new phase in q1.14. The first sample after reset gives one word;
// every later one gives STEPS-1 points stepping from the previous I/Q pair
// towards the new one, then the new pair with last set. One sample is worked
// at a time: the multiply and accumulate, then the CORDIC
// rotator (one rotation per cycle through a shared shifter), then, when a
// previous point exists, the division of the difference by STEPS through a
// reciprocal multiply, and then the output words, one per cycle when the
// output is not stalled. phase_gain sits at byte address 0 of the APB port.
module fm_modulator_linear_interp_top #(
  parameter int STEPS = fmli_pkg::STEPS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fmli_pkg::SAMPLE_W-1:0] sample,
  // output words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fmli_pkg::IQ_W-1:0]    in_phase,
  output logic signed [fmli_pkg::IQ_W-1:0]    quadrature,
  output logic                                last,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int JW = $clog2(STEPS);
  localparam int PW = fmli_pkg::PHASE_W;
  localparam int MULW = fmli_pkg::SAMPLE_W + fmli_pkg::GAIN_W + 1;

  typedef enum logic [2:0] {S_IDLE, S_ACC, S_CORDIC, S_LERP, S_FINAL} state_t;

  state_t                           state;
  logic [fmli_pkg::GAIN_W-1:0]      phase_gain;
  logic [PW-1:0]                    phase_acc;
  logic [PW-1:0]                    prod;
  logic signed [fmli_pkg::IQ_W-1:0] prev_in_phase;
  logic signed [fmli_pkg::IQ_W-1:0] prev_quadrature;
  logic                             have_previous;
  logic [JW-1:0]                    step_cnt;

  logic signed [MULW-1:0]           prod_full;
  logic [PW-1:0]                    phase_sum;
  logic                             cfg_write;
  logic                             slot_free;
  logic                             c_done;
  logic signed [fmli_pkg::IQ_W-1:0] c_sin;
  logic signed [fmli_pkg::IQ_W-1:0] c_cos;
  fmli_pkg::lerp_ctrl_t             l_ctrl;
  logic                             l_ready;
  logic signed [fmli_pkg::IQ_W-1:0] l_point_i;
  logic signed [fmli_pkg::IQ_W-1:0] l_point_q;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == fmli_pkg::REG_PHASE_GAIN) ?
                     {{(32-fmli_pkg::GAIN_W){1'b0}}, phase_gain} : '0;

  // phase increment and accumulate
  assign prod_full = sample * $signed({1'b0, phase_gain});
  assign phase_sum = phase_acc + prod;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  assign l_ctrl.start = (state == S_CORDIC) && c_done && have_previous;
  assign l_ctrl.step  = (state == S_LERP) && l_ready && slot_free;

  fmli_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_ACC),
    .phase   (phase_sum),
    .done    (c_done),
    .sin_out (c_sin),
    .cos_out (c_cos)
  );

  fmli_lerp #(
    .STEPS (STEPS)
  ) u_lerp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (l_ctrl),
    .prev_i  (prev_in_phase),
    .prev_q  (prev_quadrature),
    .new_i   (c_sin),
    .new_q   (c_cos),
    .ready   (l_ready),
    .point_i (l_point_i),
    .point_q (l_point_q)
  );

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      phase_gain      <= fmli_pkg::PHASE_GAIN_RESET;
      phase_acc       <= '0;
      prev_in_phase   <= '0;
      prev_quadrature <= '0;
      have_previous   <= 1'b0;
      step_cnt        <= '0;
    end else begin
      if (cfg_write && (paddr[2] == fmli_pkg::REG_PHASE_GAIN)) begin
        phase_gain <= pwdata[fmli_pkg::GAIN_W-1:0];
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            prod  <= prod_full[PW-1:0];
            state <= S_ACC;
          end
        end
        S_ACC: begin
          phase_acc <= phase_sum;
          state     <= S_CORDIC;
        end
        S_CORDIC: begin
          if (c_done) begin
            step_cnt <= JW'(1);
            state    <= have_previous ? S_LERP : S_FINAL;
          end
        end
        S_LERP: begin
          if (l_ready && slot_free) begin
            out_valid  <= 1'b1;
            in_phase   <= l_point_i;
            quadrature <= l_point_q;
            last       <= 1'b0;
            if (step_cnt == JW'(STEPS - 1)) begin
              state <= S_FINAL;
            end else begin
              step_cnt <= step_cnt + 1'b1;
            end
          end
        end
        S_FINAL: begin
          if (slot_free) begin
            out_valid       <= 1'b1;
            in_phase        <= c_sin;
            quadrature      <= c_cos;
            last            <= 1'b1;
            prev_in_phase   <= c_sin;
            prev_quadrature <= c_cos;
            have_previous   <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the interpolator only starts once a previous point exists
  a_lerp_needs_prev: assert property (@(posedge clk) disable iff (rst)
    l_ctrl.start |-> have_previous)
    else $error("interpolator started without a previous point");

  // the rotator finishes only while the sequencer waits for it
  a_cordic_done_state: assert property (@(posedge clk) disable iff (rst)
    c_done |-> (state == S_CORDIC))
    else $error("cordic finished outside its wait state");

  // an accepted word closes the input until the sample is done
  a_accept_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a word was taken");

  // a step is only taken while the interpolator is ready and the count is in range
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    l_ctrl.step |-> (l_ready && (step_cnt != '0) && (step_cnt <= JW'(STEPS - 1))))
    else $error("interpolation step out of range");

endmodule
